// ----- hw/rtl/mfu_pkg.sv -----
`default_nettype none

package mfu_pkg;

  localparam int MAX_WIDTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH       = 2;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int CFG_W_W  = 7;   // value_width register
  localparam int OFFSET_W = 3;   // start_bit_offset register
  localparam int NBITS_W  = 4;   // 1..8 live bits in a byte
  localparam int USED_W   = 3;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_BIT = 2;

  localparam logic [0:0] REG_VALUE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_START_OFFSET = 1'b1;

  localparam logic [CFG_W_W-1:0]  VALUE_WIDTH_RESET  = 7'd8;
  localparam logic [OFFSET_W-1:0] START_OFFSET_RESET = 3'd0;

  // one classified byte waiting for the back end; live bits sit in the low nbits
  typedef struct packed {
    logic [BYTE_W-1:0]  bits;
    logic [NBITS_W-1:0] nbits;
    logic               start;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mfu_if.sv -----
`default_nettype none

interface mfu_byte_if;
  logic                           valid;
  logic                           ready;
  logic [mfu_pkg::BYTE_W-1:0]     in_byte;
  logic                           array_start;

  modport source (output valid, output in_byte, output array_start, input ready);
  modport sink   (input valid, input in_byte, input array_start, output ready);
endinterface

interface mfu_value_if;
  logic                           valid;
  logic                           ready;
  logic [mfu_pkg::VALUE_W-1:0]    value;
  logic                           last_of_byte;

  modport source (output valid, output value, output last_of_byte, input ready);
  modport sink   (input valid, input value, input last_of_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mfu_front.sv -----
`default_nettype none

module mfu_front (
  mfu_byte_if.sink                      byte_ch,
  input  logic [mfu_pkg::OFFSET_W-1:0]  start_offset,
  input  logic                          queue_full,
  output logic                          push,
  output mfu_pkg::q_entry_t             entry
);

  assign byte_ch.ready = !queue_full;
  assign push          = byte_ch.valid && !queue_full;

  // first byte of an array loses its leading skipped bits
  always_comb begin
    entry.bits  = byte_ch.in_byte;
    entry.start = byte_ch.array_start;
    if (byte_ch.array_start) begin
      entry.nbits = mfu_pkg::NBITS_W'(mfu_pkg::BYTE_W)
                    - mfu_pkg::NBITS_W'(start_offset);
    end else begin
      entry.nbits = mfu_pkg::NBITS_W'(mfu_pkg::BYTE_W);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mfu_queue.sv -----
`default_nettype none

module mfu_queue #(
  parameter int DEPTH = mfu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfu_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output mfu_pkg::q_entry_t head,
  output logic              head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  mfu_pkg::q_entry_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign full       = (count == CNTW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mfu_back.sv -----
`default_nettype none

module mfu_back #(
  parameter int MAX_WIDTH = mfu_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]  eff_w,
  input  mfu_pkg::q_entry_t                 head,
  input  logic                              head_valid,
  output logic                              pop,
  mfu_value_if.source                       value_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NW = mfu_pkg::NBITS_W;
  localparam int UW = mfu_pkg::USED_W;
  localparam int BW = mfu_pkg::BYTE_W;

  logic [MAX_WIDTH-2:0] res_bits, res_bits_next;
  logic [CW-1:0]        res_cnt, res_cnt_next;
  logic [UW-1:0]        used, used_next;

  logic                 out_valid, out_valid_next;
  logic [mfu_pkg::VALUE_W-1:0] out_value, out_value_next;
  logic                 out_last, out_last_next;

  logic                 fresh;
  logic [MAX_WIDTH-1:0] acc0, acc_new, mask, val;
  logic [CW-1:0]        cnt0;
  logic [NW-1:0]        rem, take, rem_after;
  logic [WW-1:0]        need;
  logic [BW:0]          take_mask;
  logic [BW-1:0]        chunk;
  logic                 emit, last, step, out_free;

  always_comb begin
    // array start: residue is dropped before this byte's first bit
    fresh = head.start && (used == '0);
    acc0  = fresh ? '0 : {1'b0, res_bits};
    cnt0  = fresh ? '0 : res_cnt;
    rem   = head.nbits - NW'(used);

    // residue already at or past a shrunk width: next bit completes a value
    if (WW'(cnt0) >= eff_w) begin
      need = WW'(1);
    end else begin
      need = eff_w - WW'(cnt0);
    end

    if (need <= WW'(rem)) begin
      take = NW'(need);
      emit = 1'b1;
    end else begin
      take = rem;
      emit = 1'b0;
    end

    rem_after = rem - take;
    take_mask = ((BW + 1)'(1) << take) - (BW + 1)'(1);
    chunk     = BW'(({1'b0, head.bits} >> rem_after) & take_mask);
    acc_new   = (acc0 << take) | MAX_WIDTH'(chunk);
    mask      = {MAX_WIDTH{1'b1}} >> (WW'(MAX_WIDTH) - eff_w);
    val       = acc_new & mask;
    // no further value can complete in what is left of the byte
    last      = WW'(rem_after) < eff_w;

    out_free = !out_valid || value_ch.ready;
    step     = head_valid && (!emit || out_free);
    pop      = step && (rem_after == '0);

    res_bits_next  = res_bits;
    res_cnt_next   = res_cnt;
    used_next      = used;
    out_valid_next = out_valid;
    out_value_next = out_value;
    out_last_next  = out_last;

    if (value_ch.ready) begin
      out_valid_next = 1'b0;
    end

    if (step) begin
      if (emit) begin
        res_bits_next  = '0;
        res_cnt_next   = '0;
        out_valid_next = 1'b1;
        out_value_next = '0;
        out_value_next[MAX_WIDTH-1:0] = val;
        out_last_next  = last;
      end else begin
        res_bits_next = acc_new[MAX_WIDTH-2:0];
        res_cnt_next  = CW'(WW'(cnt0) + WW'(take));
      end
      used_next = (rem_after == '0) ? '0 : used + UW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_bits  <= '0;
      res_cnt   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      res_bits  <= res_bits_next;
      res_cnt   <= res_cnt_next;
      used      <= used_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

  assign value_ch.valid        = out_valid;
  assign value_ch.value        = out_value;
  assign value_ch.last_of_byte = out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/msb_first_field_unpacker.sv -----
`default_nettype none

// channel    dir  words                         handshake
// byte_ch    in   in_byte[7:0], array_start     valid/ready
// value_ch   out  value[63:0], last_of_byte     valid/ready
// apb        in   value_width @0x0, start_bit_offset @0x4
//
// A byte is accepted every cycle while the two-word front queue has room.
// The back end spends one step per value a byte completes, plus one step to
// fold leftover bits into the residue (or the whole byte if it completes none).
// A value passes through the queue entry and the output register; a stalled output
// holds the back end, and once the queue is full byte_ch.ready drops.
// Reset (rst, synchronous) empties queue, residue and output, width 8, offset 0.

module msb_first_field_unpacker #(
  parameter int MAX_WIDTH = mfu_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  mfu_byte_if.sink                          byte_ch,
  mfu_value_if.source                       value_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfu_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mfu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mfu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [mfu_pkg::CFG_W_W-1:0]  value_width;
  logic [mfu_pkg::OFFSET_W-1:0] start_bit_offset;
  logic [WW-1:0]                eff_w;
  logic                         cfg_write;
  logic [0:0]                   reg_idx;

  logic              q_push, q_full, q_pop, q_head_valid;
  mfu_pkg::q_entry_t q_entry, q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[mfu_pkg::REG_IDX_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      value_width      <= mfu_pkg::VALUE_WIDTH_RESET;
      start_bit_offset <= mfu_pkg::START_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        mfu_pkg::REG_VALUE_WIDTH: begin
          value_width <= pwdata[mfu_pkg::CFG_W_W-1:0];
        end
        mfu_pkg::REG_START_OFFSET: begin
          start_bit_offset <= pwdata[mfu_pkg::OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfu_pkg::REG_VALUE_WIDTH:  prdata = mfu_pkg::APB_DATA_W'(value_width);
      mfu_pkg::REG_START_OFFSET: prdata = mfu_pkg::APB_DATA_W'(start_bit_offset);
      default:                   prdata = '0;
    endcase
  end

  // zero reads as 1, anything above MAX_WIDTH as MAX_WIDTH
  always_comb begin
    priority if (value_width == '0) begin
      eff_w = WW'(1);
    end else if (value_width > mfu_pkg::CFG_W_W'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(value_width);
    end
  end

  mfu_front u_front (
    .byte_ch      (byte_ch),
    .start_offset (start_bit_offset),
    .queue_full   (q_full),
    .push         (q_push),
    .entry        (q_entry)
  );

  mfu_queue #(
    .DEPTH (mfu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  mfu_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_w      (eff_w),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .value_ch   (value_ch)
  );

  // a value never carries bits above the effective width
  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    value_ch.valid |-> ((value_ch.value >> eff_w) == '0))
    else $error("value wider than configured width");

  // nothing is shown on the output right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !value_ch.valid)
    else $error("output valid right after reset");

  // the queue never drains without having been filled
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
